/* src/acsp_pkg.sv */
// ---------------------------------------------------------------------------
// acsp_pkg
// Shared types, constants and tables for the CSI/SGR escape parser.
// ---------------------------------------------------------------------------
package acsp_pkg;

  localparam int unsigned RGB_W   = 24;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned STYLE_W = 3;

  localparam logic [RGB_W-1:0] TEXT_RGB_RST = 24'hC8C8C8;
  localparam logic [RGB_W-1:0] BACK_RGB_RST = 24'h141414;

  localparam logic [CODE_W-1:0] CODE_CAP = 10'd999;

  // parse modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // parameter string shape
  localparam logic [1:0] SHAPE_NONE  = 2'd0;
  localparam logic [1:0] SHAPE_TWO   = 2'd1;
  localparam logic [1:0] SHAPE_OTHER = 2'd2;

  // operations and event kinds
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;
  localparam logic EV_GLYPH   = 1'b0;
  localparam logic EV_CLEAR   = 1'b1;

  // config register indexes
  localparam logic CFG_TEXT_RGB = 1'b0;
  localparam logic CFG_BACK_RGB = 1'b1;

  // characters
  localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_TWO    = 8'h32;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_J      = 8'h4A;

  // SGR codes
  localparam logic [CODE_W-1:0] SGR_RESET     = 10'd0;
  localparam logic [CODE_W-1:0] SGR_BOLD      = 10'd1;
  localparam logic [CODE_W-1:0] SGR_ITALIC    = 10'd3;
  localparam logic [CODE_W-1:0] SGR_ULINE     = 10'd4;
  localparam logic [CODE_W-1:0] SGR_NO_BOLD   = 10'd22;
  localparam logic [CODE_W-1:0] SGR_NO_ITALIC = 10'd23;
  localparam logic [CODE_W-1:0] SGR_NO_ULINE  = 10'd24;
  localparam logic [CODE_W-1:0] SGR_FG_LO     = 10'd30;
  localparam logic [CODE_W-1:0] SGR_FG_HI     = 10'd37;
  localparam logic [CODE_W-1:0] SGR_BG_LO     = 10'd40;
  localparam logic [CODE_W-1:0] SGR_BG_HI     = 10'd47;
  localparam logic [CODE_W-1:0] SGR_FGB_LO    = 10'd90;
  localparam logic [CODE_W-1:0] SGR_FGB_HI    = 10'd97;
  localparam logic [CODE_W-1:0] SGR_BGB_LO    = 10'd100;
  localparam logic [CODE_W-1:0] SGR_BGB_HI    = 10'd107;

  typedef struct packed {
    logic [RGB_W-1:0]   text_rgb;
    logic [RGB_W-1:0]   back_rgb;
    logic [STYLE_W-1:0] style;
  } attr_t;

  function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hCD3131;
      4'd2:    rgb = 24'h0DBC79;
      4'd3:    rgb = 24'hE5E510;
      4'd4:    rgb = 24'h2472C8;
      4'd5:    rgb = 24'hBC3FBC;
      4'd6:    rgb = 24'h11A8CD;
      4'd7:    rgb = 24'hE5E5E5;
      4'd8:    rgb = 24'h666666;
      4'd9:    rgb = 24'hF14C4C;
      4'd10:   rgb = 24'h23D18B;
      4'd11:   rgb = 24'hF5F543;
      4'd12:   rgb = 24'h3B8EEA;
      4'd13:   rgb = 24'hD670D6;
      4'd14:   rgb = 24'h29B8DB;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  function automatic logic is_final(input logic [CHAR_W-1:0] c);
    logic f;
    f = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h7E) ||
        (c == 8'hAA) || (c == 8'hB5) || (c == 8'hBA) ||
        (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
    return f;
  endfunction

endpackage

/* src/acsp_sgr_apply.sv */
// ---------------------------------------------------------------------------
// acsp_sgr_apply
// Applies one SGR code to a set of pending attributes.
// ---------------------------------------------------------------------------
module acsp_sgr_apply (
  input  logic [acsp_pkg::CODE_W-1:0] code,
  input  acsp_pkg::attr_t             pend,
  input  acsp_pkg::attr_t             defaults,
  output acsp_pkg::attr_t             result
);
  import acsp_pkg::*;

  logic [CODE_W-1:0] fg_off;
  logic [CODE_W-1:0] bg_off;
  logic [CODE_W-1:0] fgb_off;
  logic [CODE_W-1:0] bgb_off;

  assign fg_off  = code - SGR_FG_LO;
  assign bg_off  = code - SGR_BG_LO;
  assign fgb_off = code - SGR_FGB_LO;
  assign bgb_off = code - SGR_BGB_LO;

  always_comb begin
    result = pend;
    if (code == SGR_RESET) begin
      result = defaults;
    end else if (code == SGR_BOLD) begin
      result.style[0] = 1'b1;
    end else if (code == SGR_ITALIC) begin
      result.style[1] = 1'b1;
    end else if (code == SGR_ULINE) begin
      result.style[2] = 1'b1;
    end else if (code == SGR_NO_BOLD) begin
      result.style[0] = 1'b0;
    end else if (code == SGR_NO_ITALIC) begin
      result.style[1] = 1'b0;
    end else if (code == SGR_NO_ULINE) begin
      result.style[2] = 1'b0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      result.text_rgb = palette({1'b0, fg_off[2:0]});
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      result.back_rgb = palette({1'b0, bg_off[2:0]});
    end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
      result.text_rgb = palette({1'b1, fgb_off[2:0]});
    end else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI) begin
      result.back_rgb = palette({1'b1, bgb_off[2:0]});
    end
  end

endmodule

/* src/ansi_csi_sgr_parser_top.sv */
// From input accept to result valid, a character passes the input register and then the result register.
// Throughput: one character per cycle; a stalled result holds the input register,
// whose own stall then follows the output stall.
// Reset (rst, synchronous): normal text mode, default colors, styles off,
// empty parse state; configuration registers back to their reset colors.
// ---------------------------------------------------------------------------
// ansi_csi_sgr_parser_top
// Character stream filter: tracks CSI/SGR attributes, emits glyphs and clears.
// ---------------------------------------------------------------------------
module ansi_csi_sgr_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [acsp_pkg::CHAR_W-1:0] char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        event_kind,
  output logic [acsp_pkg::CHAR_W-1:0] glyph,
  output logic [acsp_pkg::RGB_W-1:0]  text_rgb,
  output logic [acsp_pkg::RGB_W-1:0]  back_rgb,
  output logic                        bold,
  output logic                        italic,
  output logic                        underline,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [acsp_pkg::RGB_W-1:0]  cfg_data
);
  import acsp_pkg::*;

  // configuration
  logic [RGB_W-1:0] default_text_rgb;
  logic [RGB_W-1:0] default_back_rgb;
  attr_t            defaults;

  // input register
  logic              in_q_valid;
  logic              in_q_op;
  logic [CHAR_W-1:0] in_q_char;

  // parser state
  logic [1:0]        parse_mode, parse_mode_next;
  attr_t             cur, cur_next;
  attr_t             pend, pend_next;
  logic [CODE_W-1:0] code_value, code_value_next;
  logic              fl_nonempty, fl_nonempty_next;
  logic              fl_invalid, fl_invalid_next;
  logic              fl_any, fl_any_next;
  logic [1:0]        param_shape, param_shape_next;

  logic              res_valid;
  logic              res_kind;
  logic [CHAR_W-1:0] res_glyph;
  attr_t             res_attr;

  logic              advance;
  logic              proc;
  logic [CODE_W-1:0] apply_code;
  attr_t             applied;
  attr_t             finished;
  logic [13:0]       code_acc;
  logic [3:0]        digit;
  logic              is_digit;

  assign defaults  = '{text_rgb: default_text_rgb, back_rgb: default_back_rgb, style: '0};
  assign cfg_ready = 1'b1;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign proc     = in_q_valid && advance;

  assign apply_code = fl_invalid ? SGR_RESET : code_value;
  assign finished   = fl_nonempty ? applied : pend;

  assign digit    = 4'(in_q_char - CH_ZERO);
  assign is_digit = (in_q_char >= CH_ZERO) && (in_q_char <= CH_NINE);
  assign code_acc = {code_value, 3'b000} + {3'b000, code_value, 1'b0} + {10'd0, digit};

  acsp_sgr_apply u_apply (
    .code     (apply_code),
    .pend     (pend),
    .defaults (defaults),
    .result   (applied)
  );

  always_comb begin
    parse_mode_next  = parse_mode;
    cur_next         = cur;
    pend_next        = pend;
    code_value_next  = code_value;
    fl_nonempty_next = fl_nonempty;
    fl_invalid_next  = fl_invalid;
    fl_any_next      = fl_any;
    param_shape_next = param_shape;
    res_valid        = 1'b0;
    res_kind         = EV_CLEAR;
    res_glyph        = '0;
    res_attr         = '0;
    if (in_q_op == OP_CLEAR) begin
      parse_mode_next = MODE_NORMAL;
      res_valid       = 1'b1;
    end else begin
      case (parse_mode)
        MODE_ESC: begin
          if (in_q_char == CH_LBRACK) begin
            pend_next        = cur;
            code_value_next  = '0;
            fl_nonempty_next = 1'b0;
            fl_invalid_next  = 1'b0;
            fl_any_next      = 1'b0;
            param_shape_next = SHAPE_NONE;
            parse_mode_next  = MODE_CSI;
          end else begin
            parse_mode_next = MODE_NORMAL;
          end
        end
        MODE_CSI: begin
          if (is_final(in_q_char)) begin
            parse_mode_next = MODE_NORMAL;
            if (in_q_char == CH_M) begin
              fl_any_next      = fl_any || fl_nonempty;
              fl_nonempty_next = 1'b0;
              fl_invalid_next  = 1'b0;
              code_value_next  = '0;
              pend_next        = (fl_any || fl_nonempty) ? finished : defaults;
              cur_next         = pend_next;
            end else if (in_q_char == CH_J && param_shape != SHAPE_OTHER) begin
              res_valid = 1'b1;
            end
          end else begin
            param_shape_next = (param_shape == SHAPE_NONE && in_q_char == CH_TWO) ?
                               SHAPE_TWO : SHAPE_OTHER;
            if (in_q_char == CH_SEMI) begin
              pend_next        = finished;
              fl_any_next      = fl_any || fl_nonempty;
              fl_nonempty_next = 1'b0;
              fl_invalid_next  = 1'b0;
              code_value_next  = '0;
            end else begin
              fl_nonempty_next = 1'b1;
              if (is_digit) begin
                code_value_next = (code_acc > {4'd0, CODE_CAP}) ? CODE_CAP : code_acc[CODE_W-1:0];
              end else begin
                fl_invalid_next = 1'b1;
              end
            end
          end
        end
        default: begin
          if (in_q_char == CH_ESC) begin
            parse_mode_next = MODE_ESC;
          end else begin
            parse_mode_next = MODE_NORMAL;
            res_valid       = 1'b1;
            res_kind        = EV_GLYPH;
            res_glyph       = in_q_char;
            res_attr        = cur;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_text_rgb <= TEXT_RGB_RST;
      default_back_rgb <= BACK_RGB_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_RGB: default_text_rgb <= cfg_data;
        CFG_BACK_RGB: default_back_rgb <= cfg_data;
        default:      default_text_rgb <= default_text_rgb;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_op   <= operation;
      in_q_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode  <= MODE_NORMAL;
      cur         <= '{text_rgb: TEXT_RGB_RST, back_rgb: BACK_RGB_RST, style: '0};
      pend        <= '{text_rgb: TEXT_RGB_RST, back_rgb: BACK_RGB_RST, style: '0};
      code_value  <= '0;
      fl_nonempty <= 1'b0;
      fl_invalid  <= 1'b0;
      fl_any      <= 1'b0;
      param_shape <= SHAPE_NONE;
    end else if (proc) begin
      parse_mode  <= parse_mode_next;
      cur         <= cur_next;
      pend        <= pend_next;
      code_value  <= code_value_next;
      fl_nonempty <= fl_nonempty_next;
      fl_invalid  <= fl_invalid_next;
      fl_any      <= fl_any_next;
      param_shape <= param_shape_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      event_kind <= res_kind;
      glyph      <= res_glyph;
      text_rgb   <= res_attr.text_rgb;
      back_rgb   <= res_attr.back_rgb;
      bold       <= res_attr.style[0];
      italic     <= res_attr.style[1];
      underline  <= res_attr.style[2];
    end
  end

endmodule
